// ===== design/scfp_pkg.sv =====
// Package for the sync/CRC-16 frame parser.
// Holds phase encoding, framing constants, result struct and the CRC byte update.
// No dependencies.
package scfp_pkg;

  localparam logic [7:0]  SyncByte   = 8'hA5;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] MaxLenRst  = 16'd512;
  localparam logic [2:0]  HdrLast    = 3'd5;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_HDR     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  typedef enum logic {
    EV_PAYLOAD   = 1'b0,
    EV_FRAME_END = 1'b1
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  msg_type;
    logic [15:0] sequence_num;
    logic [15:0] length;
    logic        crc_good;
  } scfp_result_t;

  // CRC-16/CCITT-FALSE, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sync_crc16_frame_parser.sv =====
// Top level of the sync/CRC-16 frame parser: input register, parser, result register.
// Depends on scfp_pkg, scfp_in_stage, scfp_parser, scfp_out_stage.
//
//   channel | direction | handshake              | payload
//   rx      | in        | in_valid_i / in_stall_o | rx_byte_i
//   result  | out       | out_valid_o / out_stall_i | event_kind_o .. crc_good_o
//   config  | in        | cfg_we_i                | cfg_wdata_i (max payload length)
//
// One byte request per cycle while in_stall_o is low; a byte is held in the input register and
// its result, if any, is loaded into the result register when the parser takes the byte.
// The parser advances whenever the input register holds a byte and the result register is empty or being drained.
// Reset returns to sync hunt with the length limit at 512; held header fields clear.
// A stalled result holds the parser, which then stalls the input once its register is full.
module sync_crc16_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [7:0]  message_type_o,
  output logic [15:0] sequence_res_o,
  output logic [15:0] payload_length_o,
  output logic        crc_good_o
);
  import scfp_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_val;
  logic         out_free;
  logic         step;
  logic         res_valid;
  scfp_result_t res;
  scfp_result_t res_out;

  assign step = byte_valid & out_free;

  scfp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_val)
  );

  scfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (byte_val),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step & res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_out)
  );

  assign event_kind_o     = res_out.kind;
  assign data_byte_o      = res_out.data;
  assign byte_index_o     = res_out.index;
  assign message_type_o   = res_out.msg_type;
  assign sequence_res_o   = res_out.sequence_num;
  assign payload_length_o = res_out.length;
  assign crc_good_o       = res_out.crc_good;

endmodule

// ===== design/scfp_in_stage.sv =====
// Input register for the frame parser: holds one received byte request.
// Depends on nothing but the handshake from the parser stage.
module scfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== design/scfp_parser.sv =====
// Frame parse state, header fields, running CRC and length limit register.
// Uses scfp_pkg for phases, constants, result struct and crc16_byte.
module scfp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output scfp_pkg::scfp_result_t res_o
);
  import scfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pay_cnt_q, pay_cnt_d;
  logic        crc_cnt_q, crc_cnt_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] max_len_q;

  logic [15:0] crc_upd;
  logic [2:0]  hdr_next;
  logic        hdr_done;
  logic        too_long;
  logic [15:0] pay_next;
  logic        clear;

  assign crc_upd  = crc16_byte(crc_q, byte_i);
  assign hdr_next = hdr_cnt_q + 3'd1;
  assign hdr_done = (hdr_next >= HdrLast);
  // only looked at on the last header byte, which is the length low byte
  assign too_long = ({len_q[15:8], byte_i} > max_len_q);
  assign pay_next = pay_cnt_q + 16'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_SYNC2: begin
        phase_d = (byte_i == SyncByte) ? PH_HDR : PH_SYNC1;
      end
      PH_HDR: begin
        if (hdr_done) begin
          if (too_long) begin
            phase_d = PH_SYNC1;
          end else begin
            phase_d = (len_d != 16'd0) ? PH_PAYLOAD : PH_CRC;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pay_next >= len_q) begin
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        if (crc_cnt_q) begin
          phase_d = PH_SYNC1;
        end
      end
      default: begin
        phase_d = (byte_i == SyncByte) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    type_d      = type_q;
    seq_d       = seq_q;
    len_d       = len_q;
    pay_cnt_d   = pay_cnt_q;
    crc_cnt_d   = crc_cnt_q;
    crc_hi_d    = crc_hi_q;
    crc_d       = crc_q;
    clear       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: EV_PAYLOAD, data: byte_i, index: pay_cnt_q, msg_type: type_q,
                    sequence_num: seq_q, length: len_q, crc_good: 1'b0};
    case (phase_q)
      PH_SYNC2: begin
        if (byte_i == SyncByte) begin
          hdr_cnt_d = 3'd0;
          crc_d     = CrcInit;
        end
      end
      PH_HDR: begin
        crc_d     = crc_upd;
        hdr_cnt_d = hdr_next;
        case (hdr_cnt_q)
          3'd0:    type_d = byte_i;
          3'd1:    seq_d  = {byte_i, seq_q[7:0]};
          3'd2:    seq_d  = {seq_q[15:8], byte_i};
          3'd3:    len_d  = {byte_i, len_q[7:0]};
          default: len_d  = {len_q[15:8], byte_i};
        endcase
        if (hdr_done) begin
          pay_cnt_d = 16'd0;
          crc_cnt_d = 1'b0;
          clear     = too_long;
        end
      end
      PH_PAYLOAD: begin
        crc_d       = crc_upd;
        pay_cnt_d   = pay_next;
        res_valid_o = 1'b1;
        if (pay_next >= len_q) begin
          crc_cnt_d = 1'b0;
        end
      end
      PH_CRC: begin
        if (!crc_cnt_q) begin
          crc_hi_d  = byte_i;
          crc_cnt_d = 1'b1;
        end else begin
          res_valid_o    = 1'b1;
          res_o.kind     = EV_FRAME_END;
          res_o.data     = 8'h00;
          res_o.index    = 16'h0000;
          res_o.crc_good = ({crc_hi_q, byte_i} == crc_q);
          clear          = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (clear) begin
      hdr_cnt_d = 3'd0;
      pay_cnt_d = 16'd0;
      crc_cnt_d = 1'b0;
      crc_hi_d  = 8'h00;
      crc_d     = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      hdr_cnt_q <= 3'd0;
      type_q    <= 8'h00;
      seq_q     <= 16'h0000;
      len_q     <= 16'h0000;
      pay_cnt_q <= 16'h0000;
      crc_cnt_q <= 1'b0;
      crc_hi_q  <= 8'h00;
      crc_q     <= CrcInit;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      type_q    <= type_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      pay_cnt_q <= pay_cnt_d;
      crc_cnt_q <= crc_cnt_d;
      crc_hi_q  <= crc_hi_d;
      crc_q     <= crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== design/scfp_out_stage.sv =====
// Result register for the frame parser.
// Uses scfp_pkg for the result struct.
module scfp_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  scfp_pkg::scfp_result_t res_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  free_o,
  output scfp_pkg::scfp_result_t res_o
);
  import scfp_pkg::*;

  logic         valid_q;
  scfp_result_t res_q;

  assign free_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
